// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define TDPG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define TDPG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/tdpg_pkg.sv =====
// ----------------------------------------------------------------------------
// tdpg_pkg
// Shared constants, microcode types and the control program of the
// trial-division prime generator.
// ----------------------------------------------------------------------------
package tdpg_pkg;

  localparam int DEF_TABLE_DEPTH = 4096;
  localparam int DEF_VALUE_BITS  = 16;

  localparam int WANT_W     = 13;
  localparam int WANT_RESET = 4096;
  localparam int CFG_ADDR_W = 3;
  localparam int APB_DW     = 32;

  localparam logic [CFG_ADDR_W-3:0] REG_PRIMES_WANTED = '0;

  localparam int PRIME_FIRST = 2;
  localparam int CAND_START  = 3;

  typedef logic [3:0] upc_t;

  typedef enum logic [3:0] {
    A_NOP,
    A_LATCH,
    A_TAKE_CAND,
    A_READ,
    A_SQUARE,
    A_DIV_START,
    A_NEXT_IDX,
    A_APPEND,
    A_EMIT_CLEAR,
    A_EMIT_DONE,
    A_EMIT_SEED
  } act_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_REQ,
    C_RESTART,
    C_LIMIT,
    C_EMPTY,
    C_PAST_RANGE,
    C_IDX_END,
    C_SQ_GT,
    C_DIV_BUSY,
    C_REM_ZERO
  } cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    upc_t  target;
  } ucode_t;

  localparam upc_t S_IDLE     = 4'd0;
  localparam upc_t S_RESTART  = 4'd1;
  localparam upc_t S_LIMIT    = 4'd2;
  localparam upc_t S_EMPTY    = 4'd3;
  localparam upc_t S_CAND     = 4'd4;
  localparam upc_t S_TAKE     = 4'd5;
  localparam upc_t S_TEST     = 4'd6;
  localparam upc_t S_SQUARE   = 4'd7;
  localparam upc_t S_BOUND    = 4'd8;
  localparam upc_t S_DIV_WAIT = 4'd9;
  localparam upc_t S_CHECK    = 4'd10;
  localparam upc_t S_LOOP     = 4'd11;
  localparam upc_t S_APPEND   = 4'd12;
  localparam upc_t S_CLEAR    = 4'd13;
  localparam upc_t S_DONE     = 4'd14;
  localparam upc_t S_SEED     = 4'd15;

  function automatic ucode_t ucode_rom(upc_t pc);
    ucode_t w;
    w = '{act: A_NOP, cond: C_NEVER, target: S_IDLE};
    unique case (pc)
      S_IDLE:     w = '{act: A_LATCH,     cond: C_NO_REQ,     target: S_IDLE};
      S_RESTART:  w = '{act: A_NOP,       cond: C_RESTART,    target: S_CLEAR};
      S_LIMIT:    w = '{act: A_NOP,       cond: C_LIMIT,      target: S_DONE};
      S_EMPTY:    w = '{act: A_NOP,       cond: C_EMPTY,      target: S_SEED};
      S_CAND:     w = '{act: A_NOP,       cond: C_PAST_RANGE, target: S_DONE};
      S_TAKE:     w = '{act: A_TAKE_CAND, cond: C_NEVER,      target: S_IDLE};
      S_TEST:     w = '{act: A_READ,      cond: C_IDX_END,    target: S_APPEND};
      S_SQUARE:   w = '{act: A_SQUARE,    cond: C_NEVER,      target: S_IDLE};
      S_BOUND:    w = '{act: A_DIV_START, cond: C_SQ_GT,      target: S_APPEND};
      S_DIV_WAIT: w = '{act: A_NOP,       cond: C_DIV_BUSY,   target: S_DIV_WAIT};
      S_CHECK:    w = '{act: A_NEXT_IDX,  cond: C_REM_ZERO,   target: S_CAND};
      S_LOOP:     w = '{act: A_NOP,       cond: C_ALWAYS,     target: S_TEST};
      S_APPEND:   w = '{act: A_APPEND,    cond: C_ALWAYS,     target: S_IDLE};
      S_CLEAR:    w = '{act: A_EMIT_CLEAR, cond: C_ALWAYS,    target: S_IDLE};
      S_DONE:     w = '{act: A_EMIT_DONE, cond: C_ALWAYS,     target: S_IDLE};
      S_SEED:     w = '{act: A_EMIT_SEED, cond: C_ALWAYS,     target: S_IDLE};
      default:    w = '{act: A_NOP,       cond: C_ALWAYS,     target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== design/trial_division_prime_generator.sv =====
// Restart, done and first-prime items pass the restart, limit and empty checks in order.
// A new prime tries candidates in turn, dividing each by table primes in the bit-serial
// remainder unit; one that passes the square bound or the table end is appended.
// Throughput: one item at a time; the next item is accepted once the result is registered.
// Reset (synchronous): count 0, candidate 3, primes_wanted 4096; the prime table is not
// cleared, entries are only used after they are written.
// ----------------------------------------------------------------------------
// trial_division_prime_generator
// Microcoded trial-division prime generator with an on-chip prime table.
// ----------------------------------------------------------------------------
module trial_division_prime_generator #(
  parameter int TABLE_DEPTH = tdpg_pkg::DEF_TABLE_DEPTH,
  parameter int VALUE_BITS  = tdpg_pkg::DEF_VALUE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_restart,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [VALUE_BITS-1:0]               out_prime_value,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]    out_prime_ordinal,
  output logic                                out_done_res,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tdpg_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [tdpg_pkg::APB_DW-1:0]         pwdata,
  output logic [tdpg_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);

  import tdpg_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CMP_W = (CNT_W > WANT_W) ? CNT_W : WANT_W;

  upc_t                  upc_r, upc_nxt;
  ucode_t                uw;
  logic                  restart_r, restart_nxt;
  logic [WANT_W-1:0]     want_r, want_nxt;
  logic [CNT_W-1:0]      found_r, found_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic [VALUE_BITS:0]   cand_r, cand_nxt;
  logic [VALUE_BITS-1:0] c_r, c_nxt;
  logic [VALUE_BITS-1:0] p_r, p_nxt;
  logic [2*VALUE_BITS-1:0] sq_r, sq_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [VALUE_BITS-1:0] out_value_r, out_value_nxt;
  logic [CNT_W-1:0]      out_ord_r, out_ord_nxt;
  logic                  out_done_r, out_done_nxt;

  logic                  emit_step, hold, fire, jump, limit_hit;
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr;
  logic [VALUE_BITS-1:0] ram_wdata, ram_rdata;
  logic                  div_start, div_busy;
  logic [VALUE_BITS-1:0] div_rem;
  logic                  cfg_wr;

  tdpg_ram #(.WIDTH(VALUE_BITS), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  tdpg_rem #(.VALUE_BITS(VALUE_BITS)) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (c_r),
    .divisor  (p_r),
    .busy     (div_busy),
    .rem      (div_rem)
  );

  assign uw = ucode_rom(upc_r);

  assign limit_hit = (CMP_W'(found_r) >= CMP_W'(TABLE_DEPTH)) ||
                     (CMP_W'(found_r) >= CMP_W'(want_r));

  always_comb begin
    case (uw.act) inside
      A_APPEND, A_EMIT_CLEAR, A_EMIT_DONE, A_EMIT_SEED: emit_step = 1'b1;
      default: emit_step = 1'b0;
    endcase
  end

  assign hold = emit_step && out_valid_r && out_stall;
  assign fire = !hold;

  always_comb begin
    unique case (uw.cond)
      C_NEVER:      jump = 1'b0;
      C_ALWAYS:     jump = 1'b1;
      C_NO_REQ:     jump = !in_valid;
      C_RESTART:    jump = restart_r;
      C_LIMIT:      jump = limit_hit;
      C_EMPTY:      jump = (found_r == '0);
      C_PAST_RANGE: jump = cand_r[VALUE_BITS];
      C_IDX_END:    jump = (idx_r >= found_r);
      C_SQ_GT:      jump = (sq_r > (2*VALUE_BITS)'(c_r));
      C_DIV_BUSY:   jump = div_busy;
      C_REM_ZERO:   jump = (div_rem == '0);
      default:      jump = 1'b0;
    endcase
  end

  always_comb begin
    if (hold) begin
      upc_nxt = upc_r;
    end else if (jump) begin
      upc_nxt = uw.target;
    end else begin
      upc_nxt = upc_r + 1'b1;
    end
  end

  always_comb begin
    restart_nxt   = restart_r;
    found_nxt     = found_r;
    idx_nxt       = idx_r;
    cand_nxt      = cand_r;
    c_nxt         = c_r;
    p_nxt         = p_r;
    sq_nxt        = sq_r;
    out_value_nxt = out_value_r;
    out_ord_nxt   = out_ord_r;
    out_done_nxt  = out_done_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = found_r[AW-1:0];
    ram_wdata     = c_r;
    div_start     = 1'b0;
    if (fire) begin
      case (uw.act)
        A_LATCH: begin
          restart_nxt = in_restart;
        end
        A_TAKE_CAND: begin
          c_nxt    = cand_r[VALUE_BITS-1:0];
          cand_nxt = cand_r + 1'b1;
          idx_nxt  = '0;
        end
        A_READ: begin
          ram_re = 1'b1;
        end
        A_SQUARE: begin
          p_nxt  = ram_rdata;
          sq_nxt = ram_rdata * ram_rdata;
        end
        A_DIV_START: begin
          div_start = 1'b1;
        end
        A_NEXT_IDX: begin
          idx_nxt = idx_r + 1'b1;
        end
        A_APPEND: begin
          ram_we        = 1'b1;
          found_nxt     = found_r + 1'b1;
          out_valid_nxt = 1'b1;
          out_value_nxt = c_r;
          out_ord_nxt   = found_r + 1'b1;
          out_done_nxt  = 1'b0;
        end
        A_EMIT_CLEAR: begin
          found_nxt     = '0;
          cand_nxt      = (VALUE_BITS+1)'(CAND_START);
          out_valid_nxt = 1'b1;
          out_value_nxt = '0;
          out_ord_nxt   = '0;
          out_done_nxt  = 1'b0;
        end
        A_EMIT_DONE: begin
          out_valid_nxt = 1'b1;
          out_value_nxt = '0;
          out_ord_nxt   = found_r;
          out_done_nxt  = 1'b1;
        end
        A_EMIT_SEED: begin
          ram_we        = 1'b1;
          ram_waddr     = '0;
          ram_wdata     = VALUE_BITS'(PRIME_FIRST);
          found_nxt     = CNT_W'(1);
          out_valid_nxt = 1'b1;
          out_value_nxt = VALUE_BITS'(PRIME_FIRST);
          out_ord_nxt   = CNT_W'(1);
          out_done_nxt  = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_wr   = psel && penable && pwrite && pready &&
                    (paddr[CFG_ADDR_W-1:2] == REG_PRIMES_WANTED);
  assign want_nxt = cfg_wr ? pwdata[WANT_W-1:0] : want_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= S_IDLE;
      found_r     <= '0;
      cand_r      <= (VALUE_BITS+1)'(CAND_START);
      want_r      <= WANT_W'(WANT_RESET);
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      found_r     <= found_nxt;
      cand_r      <= cand_nxt;
      want_r      <= want_nxt;
      out_valid_r <= out_valid_nxt;
    end
    restart_r   <= restart_nxt;
    idx_r       <= idx_nxt;
    c_r         <= c_nxt;
    p_r         <= p_nxt;
    sq_r        <= sq_nxt;
    out_value_r <= out_value_nxt;
    out_ord_r   <= out_ord_nxt;
    out_done_r  <= out_done_nxt;
  end

  assign in_stall          = (upc_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_prime_value   = out_value_r;
  assign out_prime_ordinal = out_ord_r;
  assign out_done_res      = out_done_r;
  assign pready            = 1'b1;
  assign prdata            = (paddr[CFG_ADDR_W-1:2] == REG_PRIMES_WANTED) ?
                             APB_DW'(want_r) : '0;

endmodule

// ===== design/tdpg_ram.sv =====
// ----------------------------------------------------------------------------
// tdpg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tdpg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/tdpg_rem.sv =====
// ----------------------------------------------------------------------------
// tdpg_rem
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module tdpg_rem #(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [VALUE_BITS-1:0] divisor,
  output logic                  busy,
  output logic [VALUE_BITS-1:0] rem
);

  localparam int CW = $clog2(VALUE_BITS + 1);

  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0] rem_r, rem_nxt;
  logic [VALUE_BITS-1:0] dvd_r, dvd_nxt;
  logic [VALUE_BITS-1:0] dsr_r, dsr_nxt;
  logic [VALUE_BITS:0]   trial;
  logic [VALUE_BITS:0]   dsr_ext;

  assign trial   = {rem_r, dvd_r[VALUE_BITS-1]};
  assign dsr_ext = {1'b0, dsr_r};

  always_comb begin
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    dsr_nxt = dsr_r;
    if (start) begin
      cnt_nxt = CW'(VALUE_BITS);
      rem_nxt = '0;
      dvd_nxt = dividend;
      dsr_nxt = divisor;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      dvd_nxt = {dvd_r[VALUE_BITS-2:0], 1'b0};
      if (trial >= dsr_ext) begin
        rem_nxt = VALUE_BITS'(trial - dsr_ext);
      end else begin
        rem_nxt = trial[VALUE_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy = (cnt_r != '0);
  assign rem  = rem_r;

endmodule

// ===== design/tdpg_checker.sv =====
// ----------------------------------------------------------------------------
// tdpg_checker
// Port-level checks of the prime generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tdpg_checker #(
  parameter int TABLE_DEPTH = tdpg_pkg::DEF_TABLE_DEPTH,
  parameter int VALUE_BITS  = tdpg_pkg::DEF_VALUE_BITS
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [VALUE_BITS-1:0]            out_prime_value,
  input logic [$clog2(TABLE_DEPTH+1)-1:0] out_prime_ordinal,
  input logic                             out_done_res,
  input logic                             pready
);

  `TDPG_ASSERT(a_out_hold, clk, rst_n,
    out_valid && out_stall |=> out_valid && $stable(out_prime_value) &&
    $stable(out_prime_ordinal) && $stable(out_done_res),
    "stalled result item changed")

  `TDPG_ASSERT(a_done_no_prime, clk, rst_n,
    out_valid && out_done_res |-> out_prime_value == '0,
    "done result carries a prime")

  `TDPG_ASSERT(a_prime_has_ordinal, clk, rst_n,
    out_valid && !out_done_res |-> (out_prime_value == '0) == (out_prime_ordinal == '0),
    "prime value and ordinal disagree")

  `TDPG_ASSERT(a_one_item_at_a_time, clk, rst_n,
    in_valid && !in_stall |=> in_stall,
    "second item accepted while busy")

  `TDPG_ASSERT_ALWAYS(a_pready_high, clk,
    pready,
    "pready dropped")

endmodule

bind trial_division_prime_generator tdpg_checker #(
  .TABLE_DEPTH (TABLE_DEPTH),
  .VALUE_BITS  (VALUE_BITS)
) u_tdpg_checker (.*);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Trial-division prime generator testbench
// Runs a table of directed requests, restarts and count writes, then random
// phases of count writes and requests. Every accepted item is run through a
// local prime predictor and the result stream is compared field by field.
// The sender works in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tdpg_pkg::*;

  localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;
  localparam int VALUE_BITS  = DEF_VALUE_BITS;
  localparam int ORD_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned VALUE_MAX = (1 << VALUE_BITS) - 1;
  localparam int RANDOM_ITEMS = 300;
  localparam int QUIET_LIMIT  = 100000;
  localparam logic [CFG_ADDR_W-1:0] ADDR_PRIMES_WANTED = {REG_PRIMES_WANTED, 2'b00};

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [ORD_W-1:0]      ordinal;
    logic                  done;
  } prime_result_t;

  typedef enum logic [1:0] {ROW_REQ, ROW_RESTART, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t     kind;
    logic [12:0]   want;
    logic          typed;
    prime_result_t res;
  } stim_row_t;

  localparam int NUM_ROWS = 30;
  localparam stim_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{ROW_REQ,     13'd0,    1'b1, '{16'd2, 13'd1, 1'b0}},
    '{ROW_REQ,     13'd0,    1'b1, '{16'd3, 13'd2, 1'b0}},
    '{ROW_REQ,     13'd0,    1'b1, '{16'd5, 13'd3, 1'b0}},
    '{ROW_RESTART, 13'd0,    1'b1, '{16'd0, 13'd0, 1'b0}},
    '{ROW_RESTART, 13'd0,    1'b1, '{16'd0, 13'd0, 1'b0}},
    '{ROW_REQ,     13'd0,    1'b1, '{16'd2, 13'd1, 1'b0}},
    '{ROW_CFG,     13'd1,    1'b0, '0},
    '{ROW_REQ,     13'd0,    1'b1, '{16'd0, 13'd1, 1'b1}},
    '{ROW_REQ,     13'd0,    1'b1, '{16'd0, 13'd1, 1'b1}},
    '{ROW_CFG,     13'd0,    1'b0, '0},
    '{ROW_REQ,     13'd0,    1'b1, '{16'd0, 13'd1, 1'b1}},
    '{ROW_RESTART, 13'd0,    1'b1, '{16'd0, 13'd0, 1'b0}},
    '{ROW_REQ,     13'd0,    1'b1, '{16'd0, 13'd0, 1'b1}},
    '{ROW_CFG,     13'd4096, 1'b0, '0},
    '{ROW_REQ,     13'd0,    1'b1, '{16'd2, 13'd1, 1'b0}},
    '{ROW_REQ,     13'd0,    1'b0, '0},
    '{ROW_REQ,     13'd0,    1'b0, '0},
    '{ROW_REQ,     13'd0,    1'b0, '0},
    '{ROW_REQ,     13'd0,    1'b0, '0},
    '{ROW_REQ,     13'd0,    1'b0, '0},
    '{ROW_CFG,     13'd8191, 1'b0, '0},
    '{ROW_REQ,     13'd0,    1'b0, '0},
    '{ROW_REQ,     13'd0,    1'b0, '0},
    '{ROW_CFG,     13'd3,    1'b0, '0},
    '{ROW_REQ,     13'd0,    1'b1, '{16'd0, 13'd8, 1'b1}},
    '{ROW_RESTART, 13'd0,    1'b1, '{16'd0, 13'd0, 1'b0}},
    '{ROW_CFG,     13'd2,    1'b0, '0},
    '{ROW_REQ,     13'd0,    1'b0, '0},
    '{ROW_REQ,     13'd0,    1'b0, '0},
    '{ROW_REQ,     13'd0,    1'b1, '{16'd0, 13'd2, 1'b1}}
  };

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_restart = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [VALUE_BITS-1:0] out_prime_value;
  logic [ORD_W-1:0]      out_prime_ordinal;
  logic                  out_done_res;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [APB_DW-1:0]     pwdata = '0;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;

  logic [VALUE_BITS-1:0] prime_store [TABLE_DEPTH];
  int unsigned           primes_found = 0;
  int unsigned           next_candidate = CAND_START;
  int unsigned           wanted_count = WANT_RESET;

  prime_result_t         expected_primes [$];
  prime_result_t         front_result;
  int unsigned           fail_count = 0;
  int unsigned           quiet_cycles = 0;
  int unsigned           burst_left = 0;
  int unsigned           stall_left = 0;
  int unsigned           stall_mode = 0;

  trial_division_prime_generator u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_restart        (in_restart),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_prime_value   (out_prime_value),
    .out_prime_ordinal (out_prime_ordinal),
    .out_done_res      (out_done_res),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic prime_result_t compute_prime_response(input bit restart);
    prime_result_t res;
    int unsigned   limit;
    int unsigned   c;
    int unsigned   p;
    bit            composite;
    res = '0;
    if (restart) begin
      primes_found = 0;
      next_candidate = CAND_START;
      return res;
    end
    limit = (wanted_count > TABLE_DEPTH) ? TABLE_DEPTH : wanted_count;
    if (primes_found >= limit) begin
      res.ordinal = ORD_W'(primes_found);
      res.done = 1'b1;
      return res;
    end
    if (primes_found == 0) begin
      prime_store[0] = VALUE_BITS'(PRIME_FIRST);
      primes_found = 1;
      res.value = VALUE_BITS'(PRIME_FIRST);
      res.ordinal = ORD_W'(1);
      return res;
    end
    while (next_candidate <= VALUE_MAX) begin
      c = next_candidate;
      next_candidate++;
      composite = 1'b0;
      for (int i = 0; i < primes_found; i++) begin
        p = prime_store[i];
        if (p * p > c) break;
        if (c % p == 0) begin
          composite = 1'b1;
          break;
        end
      end
      if (!composite) begin
        prime_store[primes_found] = VALUE_BITS'(c);
        primes_found++;
        res.value = VALUE_BITS'(c);
        res.ordinal = ORD_W'(primes_found);
        return res;
      end
    end
    res.ordinal = ORD_W'(primes_found);
    res.done = 1'b1;
    return res;
  endfunction

  task automatic send_item(input bit restart, input bit typed, input prime_result_t typed_res);
    int unsigned   gap;
    prime_result_t predicted;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end
    burst_left--;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (in_stall);
    predicted = compute_prime_response(restart);
    expected_primes.push_back(typed ? typed_res : predicted);
  endtask

  task automatic write_primes_wanted(input logic [12:0] want);
    in_valid <= 1'b0;
    while (expected_primes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_PRIMES_WANTED;
    pwdata <= APB_DW'(want);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    wanted_count = want;
  endtask

  initial begin
    stim_row_t   row;
    int unsigned issued;
    int unsigned phase_len;
    logic [12:0] want;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < NUM_ROWS; i++) begin
      row = DIRECTED_ROWS[i];
      case (row.kind)
        ROW_CFG:     write_primes_wanted(row.want);
        ROW_RESTART: send_item(1'b1, row.typed, row.res);
        default:     send_item(1'b0, row.typed, row.res);
      endcase
    end

    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       want = 13'd0;
        1:       want = 13'd1;
        2:       want = 13'd4096;
        3:       want = 13'd8191;
        default: want = 13'($urandom_range(2, 150));
      endcase
      write_primes_wanted(want);
      if ($urandom_range(0, 2) == 0) begin
        send_item(1'b1, 1'b0, '0);
        issued++;
      end
      phase_len = $urandom_range(10, 40);
      repeat (phase_len) begin
        send_item($urandom_range(0, 24) == 0, 1'b0, '0);
        issued++;
      end
    end

    in_valid <= 1'b0;
    while (expected_primes.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // hold long stall runs, random stalls or none, switching mode now and then
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= ($urandom_range(0, 9) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_primes.size() == 0) begin
        $error("unexpected item: prime_value %0d prime_ordinal %0d done_res %0b",
               out_prime_value, out_prime_ordinal, out_done_res);
        fail_count++;
      end else begin
        front_result = expected_primes.pop_front();
        if (out_prime_value !== front_result.value) begin
          $error("prime_value expected %0d actual %0d", front_result.value, out_prime_value);
          fail_count++;
        end
        if (out_prime_ordinal !== front_result.ordinal) begin
          $error("prime_ordinal expected %0d actual %0d",
                 front_result.ordinal, out_prime_ordinal);
          fail_count++;
        end
        if (out_done_res !== front_result.done) begin
          $error("done_res expected %0b actual %0b", front_result.done, out_done_res);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
